>>> hw/rtl/cfgimg_pkg.sv
package cfgimg_pkg;

   localparam int unsigned LEN_W   = 13;
   localparam int unsigned CRC_W   = 32;

   localparam logic [31:0]      IMG_MAGIC       = 32'h3143_474D;
   localparam logic [15:0]      IMG_VERSION     = 16'h0001;
   localparam logic [CRC_W-1:0] CRC_POLY        = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0] MIN_IMAGE_BYTES = 13'd12;
   localparam logic [LEN_W-1:0] LEN_RESET       = 13'd1536;
   localparam logic [LEN_W-1:0] CRC_TAIL_BYTES  = 13'd4;

   typedef enum logic [2:0] {
      FAULT_OK       = 3'd0,
      FAULT_MAGIC    = 3'd1,
      FAULT_VERSION  = 3'd2,
      FAULT_LENGTH   = 3'd3,
      FAULT_CRC      = 3'd4,
      FAULT_READ_ERR = 3'd5
   } fault_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       read_error;
   } item_type;

   typedef struct packed {
      logic             image_valid;
      fault_type        fault;
      logic [CRC_W-1:0] computed_crc;
   } result_type;

endpackage

>>> hw/rtl/cfgimg_crc_step.sv
module cfgimg_crc_step (
   input  logic [cfgimg_pkg::CRC_W-1:0] crc_cur,
   input  logic [7:0]                   data_byte,
   output logic [cfgimg_pkg::CRC_W-1:0] crc_next
);

   // Reflected CRC-32, one byte: eight shift-and-conditional-xor steps
   always_comb begin
      logic [cfgimg_pkg::CRC_W-1:0] c;
      c = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? cfgimg_pkg::CRC_POLY : '0);
      end
      crc_next = c;
   end

endmodule

>>> hw/rtl/cfgimg_check.sv
module cfgimg_check #(
   parameter int unsigned MAX_IMAGE_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  cfgimg_pkg::item_type          item,
   input  logic [cfgimg_pkg::LEN_W-1:0]  image_length,
   output logic                          has_result,
   output cfgimg_pkg::result_type        result
);

   localparam int unsigned LEN_MAX_CODE = (1 << cfgimg_pkg::LEN_W) - 1;
   localparam logic [cfgimg_pkg::LEN_W-1:0] LEN_CLAMP =
      (MAX_IMAGE_BYTES > LEN_MAX_CODE) ? cfgimg_pkg::LEN_W'(LEN_MAX_CODE)
                                       : cfgimg_pkg::LEN_W'(MAX_IMAGE_BYTES);

   logic [cfgimg_pkg::LEN_W-1:0] byte_count_ff, byte_count_in;
   logic [cfgimg_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic [31:0]                  magic_ff, magic_in;
   logic [15:0]                  version_ff, version_in;
   logic [15:0]                  length_ff, length_in;
   logic [31:0]                  stored_ff, stored_in;
   logic                         active_ff, active_in;

   logic [cfgimg_pkg::LEN_W-1:0] len;
   logic [cfgimg_pkg::LEN_W-1:0] off;
   logic [cfgimg_pkg::LEN_W-1:0] body_len;
   logic [cfgimg_pkg::LEN_W-1:0] tail_idx;
   logic [cfgimg_pkg::LEN_W:0]   off_next;
   logic [cfgimg_pkg::CRC_W-1:0] crc_base;
   logic [cfgimg_pkg::CRC_W-1:0] crc_upd;
   logic [cfgimg_pkg::CRC_W-1:0] crc_fin;
   logic                         live;

   cfgimg_crc_step u_crc_step (
      .crc_cur   (crc_base),
      .data_byte (item.data_byte),
      .crc_next  (crc_upd)
   );

   always_comb begin
      if (image_length < cfgimg_pkg::MIN_IMAGE_BYTES) begin
         len = cfgimg_pkg::MIN_IMAGE_BYTES;
      end else if (image_length > LEN_CLAMP) begin
         len = LEN_CLAMP;
      end else begin
         len = image_length;
      end
   end

   assign off      = item.first_byte ? '0 : byte_count_ff;
   assign crc_base = item.first_byte ? cfgimg_pkg::CRC_ALL_ONES : crc_ff;
   assign body_len = len - cfgimg_pkg::CRC_TAIL_BYTES;
   assign tail_idx = off - body_len;
   assign off_next = {1'b0, off} + (cfgimg_pkg::LEN_W + 1)'(1);
   assign live     = item.first_byte | active_ff;

   always_comb begin
      // start from the restarted or carried image state
      magic_in      = item.first_byte ? '0 : magic_ff;
      version_in    = item.first_byte ? '0 : version_ff;
      length_in     = item.first_byte ? '0 : length_ff;
      stored_in     = item.first_byte ? '0 : stored_ff;
      crc_in        = crc_base;
      crc_fin       = '0;
      byte_count_in = off;
      active_in     = live;
      has_result    = 1'b0;
      result        = '{image_valid: 1'b0, fault: cfgimg_pkg::FAULT_OK,
                        computed_crc: '0};

      if (live && item.read_error) begin
         active_in         = 1'b0;
         has_result        = 1'b1;
         result.fault      = cfgimg_pkg::FAULT_READ_ERR;
      end else if (live) begin
         if (off < 13'd4) begin
            magic_in[{off[1:0], 3'b000} +: 8] =
               magic_in[{off[1:0], 3'b000} +: 8] | item.data_byte;
         end else if (off < 13'd6) begin
            version_in[{off[0], 3'b000} +: 8] =
               version_in[{off[0], 3'b000} +: 8] | item.data_byte;
         end else if (off < 13'd8) begin
            length_in[{off[0], 3'b000} +: 8] =
               length_in[{off[0], 3'b000} +: 8] | item.data_byte;
         end

         if (off < body_len) begin
            crc_in = crc_upd;
         end else if (off < len) begin
            stored_in[{tail_idx[1:0], 3'b000} +: 8] =
               stored_in[{tail_idx[1:0], 3'b000} +: 8] | item.data_byte;
         end

         byte_count_in = off_next[cfgimg_pkg::LEN_W-1:0];

         if (off_next >= {1'b0, len}) begin
            crc_fin             = crc_in ^ cfgimg_pkg::CRC_ALL_ONES;
            active_in           = 1'b0;
            has_result          = 1'b1;
            result.computed_crc = crc_fin;
            if (magic_in != cfgimg_pkg::IMG_MAGIC) begin
               result.fault = cfgimg_pkg::FAULT_MAGIC;
            end else if (version_in != cfgimg_pkg::IMG_VERSION) begin
               result.fault = cfgimg_pkg::FAULT_VERSION;
            end else if (length_in != {3'b000, len}) begin
               result.fault = cfgimg_pkg::FAULT_LENGTH;
            end else if (stored_in != crc_fin) begin
               result.fault = cfgimg_pkg::FAULT_CRC;
            end else begin
               result.image_valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         byte_count_ff <= '0;
      end else if (advance) begin
         active_ff     <= active_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         crc_ff     <= crc_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         length_ff  <= length_in;
         stored_ff  <= stored_in;
      end
   end

endmodule

>>> hw/rtl/config_image_validator.sv
// Configuration image checker.
// The req channel carries one image byte per item: tdata[7:0] is the byte,
// tuser[0] marks offset zero and restarts the check, tuser[1] flags a failed
// flash read. The header (magic, version, length) is captured from the first
// eight bytes and a reflected CRC-32 runs over all but the last four bytes.
// When the image length set on the csr port is reached, one verdict item goes
// out on the rsp channel (valid flag, fault code, computed CRC). A read error
// on an active image sends a read-error verdict at once.
// An accepted item is held in the input register and processed when it
// advances; its verdict is then loaded into the rsp register that drives
// rsp_tvalid. One item per cycle is accepted back to back unless rsp stalls;
// the byte-wide CRC update is a single combinational step between the input
// register and the state registers.
// Reset clears the valid flags of both registers and leaves the checker idle
// with image length 1536. When rsp stalls, the waiting item in the input
// register holds and req_tready drops only once that register is full.
module config_image_validator #(
   parameter int unsigned MAX_IMAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] first_byte, [1] read_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] image_valid, [3:1] fault,
                                    // [35:4] computed_crc, [39:36] zero
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   logic                         in_valid_ff;
   cfgimg_pkg::item_type         in_item_ff;
   logic                         out_valid_ff;
   cfgimg_pkg::result_type       out_result_ff;
   logic [cfgimg_pkg::LEN_W-1:0] image_length_ff;

   logic                         advance;
   logic                         has_result;
   cfgimg_pkg::result_type       result;

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   cfgimg_check #(
      .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
   ) u_check (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .image_length (image_length_ff),
      .has_result   (has_result),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         image_length_ff <= cfgimg_pkg::LEN_RESET;
      end else if (csr_wr_en) begin
         image_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= '{data_byte: req_tdata, first_byte: req_tuser[0],
                         read_error: req_tuser[1]};
      end
   end

   // load a verdict, or drop the shown one once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.computed_crc,
                        out_result_ff.fault, out_result_ff.image_valid};

endmodule

>>> sim/tb_config_image_validator.sv
module tb_config_image_validator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BYTES = 4096;

   typedef enum int {
      KIND_GOOD,
      KIND_MAGIC,
      KIND_VERSION,
      KIND_LENGTH,
      KIND_CRC,
      KIND_READ_ERR,
      KIND_CUT,
      KIND_NOISE
   } image_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] data_byte
   logic [1:0]  req_tuser = 2'd0;    // [0] first_byte, [1] read_error
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [0] image_valid, [3:1] fault,
                                     // [35:4] computed_crc, [39:36] zero
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = 13'd0;

   // Checker copy of the register and the image state
   logic [12:0] len_reg = cfgimg_pkg::LEN_RESET;
   logic [12:0] byte_pos = '0;
   logic [31:0] crc_run = '1;
   logic [31:0] magic_acc = '0;
   logic [15:0] version_acc = '0;
   logic [15:0] length_acc = '0;
   logic [31:0] stored_acc = '0;
   logic        image_open = 1'b0;

   cfgimg_pkg::result_type verdict_q[$];
   int         errors = 0;
   int         bytes_taken = 0;
   bit         no_gaps = 1'b0;
   int         stall_left = 0;

   config_image_validator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ cfgimg_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic int eff_length();
      int n;
      n = len_reg;
      if (n < cfgimg_pkg::MIN_IMAGE_BYTES) n = cfgimg_pkg::MIN_IMAGE_BYTES;
      if (n > MAX_BYTES) n = MAX_BYTES;
      return n;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Advance the image state by one accepted item and queue any verdict
   task automatic predict_verdict(input logic [7:0] b, input logic first, input logic rerr);
      int                     lim;
      int                     off;
      cfgimg_pkg::result_type v;
      if (first) begin
         byte_pos    = '0;
         crc_run     = '1;
         magic_acc   = '0;
         version_acc = '0;
         length_acc  = '0;
         stored_acc  = '0;
         image_open  = 1'b1;
      end
      if (!image_open) return;
      bytes_taken++;
      if (rerr) begin
         image_open     = 1'b0;
         v.image_valid  = 1'b0;
         v.fault        = cfgimg_pkg::FAULT_READ_ERR;
         v.computed_crc = '0;
         verdict_q.push_back(v);
         return;
      end
      lim = eff_length();
      off = byte_pos;
      if (off < 4) magic_acc |= 32'(b) << (8 * off);
      else if (off < 6) version_acc |= 16'(b) << (8 * (off - 4));
      else if (off < 8) length_acc |= 16'(b) << (8 * (off - 6));
      if (off < lim - 4) crc_run = crc_update(crc_run, b);
      else if (off < lim) stored_acc |= 32'(b) << (8 * (off - (lim - 4)));
      byte_pos = 13'(off + 1);
      if (off + 1 < lim) return;
      image_open     = 1'b0;
      v.computed_crc = ~crc_run;
      if (magic_acc != cfgimg_pkg::IMG_MAGIC) v.fault = cfgimg_pkg::FAULT_MAGIC;
      else if (version_acc != cfgimg_pkg::IMG_VERSION) v.fault = cfgimg_pkg::FAULT_VERSION;
      else if (length_acc != 16'(lim)) v.fault = cfgimg_pkg::FAULT_LENGTH;
      else if (stored_acc != v.computed_crc) v.fault = cfgimg_pkg::FAULT_CRC;
      else v.fault = cfgimg_pkg::FAULT_OK;
      v.image_valid = (v.fault == cfgimg_pkg::FAULT_OK);
      verdict_q.push_back(v);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic first, input logic rerr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {rerr, first};
      do @(posedge clock); while (!req_tready);
      predict_verdict(b, first, rerr);
   endtask

   // Hold off the input until every verdict is out and the pipeline is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      for (int i = 0; i < 500000 && verdict_q.size() != 0; i++) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_length(input logic [12:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      len_reg = v;
   endtask

   // Build a well-formed image at the current length, then damage it as asked
   task automatic send_image(input image_kind_type kind, input int at);
      int          lim;
      int          stop;
      int          err_at;
      int          idx;
      logic [31:0] sum;
      logic [7:0]  img[];
      lim = eff_length();
      img = new[lim];
      foreach (img[i]) img[i] = 8'($urandom);
      for (int k = 0; k < 4; k++) img[k] = cfgimg_pkg::IMG_MAGIC[8*k +: 8];
      img[4] = cfgimg_pkg::IMG_VERSION[7:0];
      img[5] = cfgimg_pkg::IMG_VERSION[15:8];
      img[6] = lim[7:0];
      img[7] = lim[15:8];
      sum = '1;
      for (int k = 0; k < lim - 4; k++) sum = crc_update(sum, img[k]);
      sum = ~sum;
      for (int k = 0; k < 4; k++) img[lim - 4 + k] = sum[8*k +: 8];
      idx = -1;
      case (kind)
         KIND_MAGIC:   idx = $urandom_range(0, 3);
         KIND_VERSION: idx = $urandom_range(4, 5);
         KIND_LENGTH:  idx = $urandom_range(6, 7);
         KIND_CRC:     idx = $urandom_range(8, lim - 1);
         KIND_NOISE: begin
            for (int k = 0; k < 8; k++) img[k] = 8'($urandom);
         end
         default: ;
      endcase
      if (idx >= 0) img[idx] ^= 8'(1 << $urandom_range(0, 7));
      stop   = lim;
      err_at = -1;
      if (kind == KIND_READ_ERR) begin
         err_at = (at >= 0) ? at : $urandom_range(0, lim - 1);
         stop   = err_at + 1;
      end
      if (kind == KIND_CUT) stop = (at >= 0) ? at : $urandom_range(1, lim - 1);
      for (int k = 0; k < stop; k++) send_byte(img[k], k == 0, k == err_at);
   endtask

   task automatic test_reset_length();
      send_image(KIND_GOOD, -1);
   endtask

   task automatic test_idle_items();
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   task automatic test_fault_codes();
      set_length(13'd16);
      send_image(KIND_GOOD, -1);
      send_image(KIND_MAGIC, -1);
      send_image(KIND_VERSION, -1);
      send_image(KIND_LENGTH, -1);
      send_image(KIND_CRC, -1);
      send_image(KIND_READ_ERR, 0);
      send_image(KIND_READ_ERR, 9);
      send_image(KIND_CUT, 7);
      send_image(KIND_GOOD, -1);
   endtask

   task automatic test_length_limits();
      set_length(13'd0);
      send_image(KIND_GOOD, -1);
      set_length(13'd11);
      send_image(KIND_CRC, -1);
      set_length(13'd12);
      send_image(KIND_GOOD, -1);
      set_length(13'd8191);
      send_image(KIND_READ_ERR, 12);
      set_length(13'd4096);
      send_image(KIND_READ_ERR, 30);
      set_length(13'd4097);
      send_image(KIND_CUT, 20);
   endtask

   task automatic test_length_change();
      set_length(13'd40);
      send_image(KIND_CUT, 20);
      // shrink below the bytes already seen: the next byte ends the image
      set_length(13'd16);
      send_byte(8'($urandom), 1'b0, 1'b0);
      send_image(KIND_CUT, 10);
      set_length(13'd24);
      repeat (14) send_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   task automatic test_random_images();
      int             goal;
      int             r;
      int             images;
      image_kind_type kind;
      goal   = bytes_taken + 400;
      images = 0;
      while (bytes_taken < goal) begin
         if (images % 8 == 0) begin
            r = $urandom_range(0, 19);
            if (r == 0) set_length(13'($urandom_range(0, 11)));
            else if (r == 1) set_length(13'($urandom_range(65, 300)));
            else set_length(13'($urandom_range(12, 64)));
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 55) kind = KIND_GOOD;
         else if (r < 62) kind = KIND_MAGIC;
         else if (r < 69) kind = KIND_VERSION;
         else if (r < 76) kind = KIND_LENGTH;
         else if (r < 85) kind = KIND_CRC;
         else if (r < 91) kind = KIND_READ_ERR;
         else if (r < 96) kind = KIND_CUT;
         else kind = KIND_NOISE;
         send_image(kind, -1);
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
         images++;
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin
      if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cfgimg_pkg::result_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected verdict item: tdata %h", rsp_tdata);
            errors++;
         end else begin
            v = verdict_q.pop_front();
            if (rsp_tdata[0] !== v.image_valid) begin
               $error("image_valid: expected %0b, got %0b", v.image_valid, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[3:1] !== v.fault) begin
               $error("fault: expected %0d, got %0d", v.fault, rsp_tdata[3:1]);
               errors++;
            end
            if (rsp_tdata[35:4] !== v.computed_crc) begin
               $error("computed_crc: expected %h, got %h", v.computed_crc, rsp_tdata[35:4]);
               errors++;
            end
            if (rsp_tdata[39:36] !== 4'd0) begin
               $error("pad: expected 0, got %h", rsp_tdata[39:36]);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_length();
      test_idle_items();
      test_fault_codes();
      test_length_limits();
      test_length_change();
      test_random_images();
      drain();
      repeat (10) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $error("verdicts never seen: %0d", verdict_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("config_image_validator verification clean");
      end else begin
         $display("config_image_validator verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("config_image_validator verification failed");
      $finish;
   end

endmodule
